// ===== hdl/fsdc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsdc_pkg
// Types and constants shared by the flight stage deploy controller modules.
// ----------------------------------------------------------------------------
package fsdc_pkg;

  localparam int unsigned AltW      = 24;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned IntervalW = 13;
  localparam int unsigned StageW    = 3;
  localparam int unsigned LiftoffW  = 20;
  localparam int unsigned DropW     = 17;
  localparam int unsigned DelayW    = 16;
  localparam int unsigned MainW     = 20;
  localparam int unsigned StepW     = 17;
  localparam int unsigned WindowW   = 20;

  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 80;
  localparam int unsigned PaddrW    = 5;
  localparam int unsigned PdataW    = 32;

  localparam logic [IntervalW-1:0] IntervalGround  = 13'd2000;
  localparam logic [IntervalW-1:0] IntervalRising  = 13'd1000;
  localparam logic [IntervalW-1:0] IntervalDescent = 13'd500;
  localparam logic [IntervalW-1:0] IntervalLanded  = 13'd5000;

  localparam logic signed [AltW-1:0] GroundAltReset  = 24'sd0;
  localparam logic [LiftoffW-1:0]    LiftoffReset    = 20'd5000;
  localparam logic [DropW-1:0]       ApogeeDropReset = 17'd100;
  localparam logic [DelayW-1:0]      DrogueDelReset  = 16'd1000;
  localparam logic [MainW-1:0]       MainHeightReset = 20'd10000;
  localparam logic [StepW-1:0]       LandStepReset   = 17'd100;
  localparam logic [WindowW-1:0]     LandWinReset    = 20'd10000;

  typedef enum logic [StageW-1:0] {
    ST_GROUND  = 3'd0,
    ST_RISING  = 3'd1,
    ST_APOGEE  = 3'd2,
    ST_FALLING = 3'd3,
    ST_LANDED  = 3'd4
  } stage_e;

  typedef enum logic [2:0] {
    REG_GROUND_ALT   = 3'd0,
    REG_LIFTOFF      = 3'd1,
    REG_APOGEE_DROP  = 3'd2,
    REG_DROGUE_DELAY = 3'd3,
    REG_MAIN_HEIGHT  = 3'd4,
    REG_LAND_STEP    = 3'd5,
    REG_LAND_WINDOW  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [AltW-1:0] ground_alt;
    logic [LiftoffW-1:0]    liftoff_height;
    logic [DropW-1:0]       apogee_drop;
    logic [DelayW-1:0]      drogue_delay;
    logic [MainW-1:0]       main_height;
    logic [StepW-1:0]       landing_step;
    logic [WindowW-1:0]     land_window;
  } cfg_t;

  typedef struct packed {
    stage_e                 stage;
    logic signed [AltW-1:0] last_alt;
    logic [IntervalW-1:0]   interval;
    logic [TimeW-1:0]       apo_time;
    logic signed [AltW-1:0] apo_alt;
    logic                   drogue_done;
    logic                   main_done;
  } flight_state_t;

endpackage

// ===== hdl/fsdc_step.sv =====
// ----------------------------------------------------------------------------
// fsdc_step
// Next flight state for one altitude sample; stage checks cascade in order.
// ----------------------------------------------------------------------------
module fsdc_step (
  input  fsdc_pkg::cfg_t                         cfg_i,
  input  fsdc_pkg::flight_state_t                state_i,
  input  logic signed [fsdc_pkg::AltW-1:0]       alt_i,
  input  logic        [fsdc_pkg::TimeW-1:0]      time_i,
  output fsdc_pkg::flight_state_t                state_o
);

  logic signed [fsdc_pkg::AltW:0]   drop;
  logic signed [fsdc_pkg::AltW:0]   height;
  logic        [fsdc_pkg::AltW:0]   drop_abs;
  logic        [fsdc_pkg::AltW:0]   height_abs;
  logic signed [fsdc_pkg::AltW+4:0] drop_x10;

  assign drop   = {state_i.last_alt[fsdc_pkg::AltW-1], state_i.last_alt}
                - {alt_i[fsdc_pkg::AltW-1], alt_i};
  assign height = {alt_i[fsdc_pkg::AltW-1], alt_i}
                - {cfg_i.ground_alt[fsdc_pkg::AltW-1], cfg_i.ground_alt};

  assign drop_abs   = drop[fsdc_pkg::AltW]   ? 25'(-drop)   : 25'(drop);
  assign height_abs = height[fsdc_pkg::AltW] ? 25'(-height) : 25'(height);
  assign drop_x10   = (29'(drop) <<< 3) + (29'(drop) <<< 1);

  always_comb begin
    logic [fsdc_pkg::TimeW-1:0] since;
    state_o = state_i;
    since   = '0;
    if (state_o.stage == fsdc_pkg::ST_GROUND) begin
      state_o.interval = fsdc_pkg::IntervalGround;
      if (height > $signed({5'b0, cfg_i.liftoff_height})) begin
        state_o.stage = fsdc_pkg::ST_RISING;
      end
    end
    if (state_o.stage == fsdc_pkg::ST_RISING) begin
      state_o.interval = fsdc_pkg::IntervalRising;
      if (drop > $signed({8'b0, cfg_i.apogee_drop})) begin
        state_o.stage    = fsdc_pkg::ST_APOGEE;
        state_o.apo_time = time_i;
        state_o.apo_alt  = alt_i;
      end
    end
    if (state_o.stage == fsdc_pkg::ST_APOGEE) begin
      state_o.interval = fsdc_pkg::IntervalDescent;
      if (drop_x10 > $signed({16'b0, state_i.interval})) begin
        state_o.stage = fsdc_pkg::ST_FALLING;
      end
    end
    if (state_o.stage == fsdc_pkg::ST_FALLING) begin
      state_o.interval = fsdc_pkg::IntervalDescent;
      since = time_i - state_o.apo_time;
      if (since > {16'b0, cfg_i.drogue_delay}) begin
        state_o.drogue_done = 1'b1;
      end
      if (height < $signed({5'b0, cfg_i.main_height})) begin
        state_o.main_done = 1'b1;
      end
      if ((drop_abs < {8'b0, cfg_i.landing_step}) &&
          (height_abs < {5'b0, cfg_i.land_window})) begin
        state_o.stage = fsdc_pkg::ST_LANDED;
      end
    end
    if (state_o.stage == fsdc_pkg::ST_LANDED) begin
      state_o.interval = fsdc_pkg::IntervalLanded;
    end
    state_o.last_alt = alt_i;
  end

endmodule

// ===== hdl/flight_stage_deploy_controller_unit.sv =====
// ----------------------------------------------------------------------------
// flight_stage_deploy_controller_unit
// Flight stage tracking with drogue and main deployment for altitude samples.
//
//   channel  | direction | contents
//   s_*      | in        | altitude_cm, time_ms
//   m_*      | out       | stage, drogue, main, next interval, apogee alt/time
//   APB      | in/out    | seven configuration registers at 4*index
//
// One sample per cycle sustained while m_tready_i stays high; an accepted sample
// passes the input register, one pass of stage logic and the result register.
// Flight state updates as the sample moves into the result register.
// Reset clears the stage to ground and loads the default register values.
// A stalled result holds; the input register still takes one more sample.
// ----------------------------------------------------------------------------
module flight_stage_deploy_controller_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  // [23:0] altitude_cm, [55:24] time_ms
  input  logic [fsdc_pkg::InDataW-1:0]      s_tdata_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  // [2:0] flight_stage, [3] drogue_fire, [4] main_fire, [17:5] next_interval_ms,
  // [41:18] apogee_altitude_out, [73:42] apogee_time_out, [79:74] zero
  output logic [fsdc_pkg::OutDataW-1:0]     m_tdata_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fsdc_pkg::PaddrW-1:0]       paddr,
  input  logic [fsdc_pkg::PdataW-1:0]       pwdata,
  output logic [fsdc_pkg::PdataW-1:0]       prdata,
  output logic                              pready
);

  fsdc_pkg::cfg_t           cfg_q;
  fsdc_pkg::flight_state_t  st_q;
  fsdc_pkg::flight_state_t  st_d;

  logic                                in_valid_q;
  logic signed [fsdc_pkg::AltW-1:0]    in_alt_q;
  logic        [fsdc_pkg::TimeW-1:0]   in_time_q;
  logic                                out_valid_q;
  logic [fsdc_pkg::OutDataW-1:0]       out_data_q;
  logic [fsdc_pkg::OutDataW-1:0]       out_data_d;

  logic                                advance;
  logic                                cfg_wr;
  fsdc_pkg::reg_idx_e                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = fsdc_pkg::reg_idx_e'(paddr[4:2]);

  assign advance    = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || advance;
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  fsdc_step u_step (
    .cfg_i   (cfg_q),
    .state_i (st_q),
    .alt_i   (in_alt_q),
    .time_i  (in_time_q),
    .state_o (st_d)
  );

  assign out_data_d = {6'b0, st_d.apo_time, st_d.apo_alt, st_d.interval,
                       st_d.main_done, st_d.drogue_done, st_d.stage};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ground_alt     <= fsdc_pkg::GroundAltReset;
      cfg_q.liftoff_height <= fsdc_pkg::LiftoffReset;
      cfg_q.apogee_drop    <= fsdc_pkg::ApogeeDropReset;
      cfg_q.drogue_delay   <= fsdc_pkg::DrogueDelReset;
      cfg_q.main_height    <= fsdc_pkg::MainHeightReset;
      cfg_q.landing_step   <= fsdc_pkg::LandStepReset;
      cfg_q.land_window    <= fsdc_pkg::LandWinReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fsdc_pkg::REG_GROUND_ALT:   cfg_q.ground_alt     <= pwdata[23:0];
        fsdc_pkg::REG_LIFTOFF:      cfg_q.liftoff_height <= pwdata[19:0];
        fsdc_pkg::REG_APOGEE_DROP:  cfg_q.apogee_drop    <= pwdata[16:0];
        fsdc_pkg::REG_DROGUE_DELAY: cfg_q.drogue_delay   <= pwdata[15:0];
        fsdc_pkg::REG_MAIN_HEIGHT:  cfg_q.main_height    <= pwdata[19:0];
        fsdc_pkg::REG_LAND_STEP:    cfg_q.landing_step   <= pwdata[16:0];
        fsdc_pkg::REG_LAND_WINDOW:  cfg_q.land_window    <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      fsdc_pkg::REG_GROUND_ALT:   prdata = {8'b0, cfg_q.ground_alt};
      fsdc_pkg::REG_LIFTOFF:      prdata = {12'b0, cfg_q.liftoff_height};
      fsdc_pkg::REG_APOGEE_DROP:  prdata = {15'b0, cfg_q.apogee_drop};
      fsdc_pkg::REG_DROGUE_DELAY: prdata = {16'b0, cfg_q.drogue_delay};
      fsdc_pkg::REG_MAIN_HEIGHT:  prdata = {12'b0, cfg_q.main_height};
      fsdc_pkg::REG_LAND_STEP:    prdata = {15'b0, cfg_q.landing_step};
      fsdc_pkg::REG_LAND_WINDOW:  prdata = {12'b0, cfg_q.land_window};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.stage       <= fsdc_pkg::ST_GROUND;
      st_q.last_alt    <= fsdc_pkg::GroundAltReset;
      st_q.interval    <= fsdc_pkg::IntervalGround;
      st_q.apo_time    <= '0;
      st_q.apo_alt     <= '0;
      st_q.drogue_done <= 1'b0;
      st_q.main_done   <= 1'b0;
    end else if (cfg_wr && (cfg_idx == fsdc_pkg::REG_GROUND_ALT)) begin
      st_q.last_alt <= pwdata[23:0];
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_tready_o) begin
        in_valid_q <= s_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_alt_q  <= s_tdata_i[23:0];
      in_time_q <= s_tdata_i[55:24];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule
